@@ src/mexp_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// mexp_pkg: shared types, constants and microcode for modular exponentiation
// Holds the operand width, the control word layout and the program ROM.
// ============================================================================
package mexp_pkg;

  localparam int OPERAND_WIDTH = 32;
  localparam int CNT_W         = (OPERAND_WIDTH > 1) ? $clog2(OPERAND_WIDTH) : 1;
  localparam int UPC_W         = 5;

  typedef logic [OPERAND_WIDTH-1:0] operand_t;
  typedef logic [UPC_W-1:0]         upc_t;

  // Jump conditions of a microinstruction
  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_WAIT_START,
    COND_EXP_ZERO,
    COND_MOD_ZERO,
    COND_BIT_CLR,
    COND_MUL_BUSY
  } cond_t;

  // Multiplicand select for the modular multiplier
  typedef enum logic [1:0] {
    MSEL_ONE,
    MSEL_ACC,
    MSEL_BASE
  } msel_t;

  // Writeback target of the multiplier result
  typedef enum logic [1:0] {
    WB_NONE,
    WB_BASE,
    WB_ACC
  } wb_t;

  typedef struct packed {
    cond_t cond;
    upc_t  target;
    logic  mul_go;
    msel_t msel;
    wb_t   wb;
    logic  shift_exp;
    logic  emit;
    logic  clr_acc;
  } ctrl_word_t;

  typedef struct packed {
    logic start;
    logic exp_zero;
    logic exp_bit0;
    logic mod_zero;
    logic mul_busy;
  } status_t;

  // Program addresses
  localparam upc_t UA_IDLE     = 5'd0;
  localparam upc_t UA_CHK_EXP  = 5'd1;
  localparam upc_t UA_CHK_MOD  = 5'd2;
  localparam upc_t UA_RED_GO   = 5'd3;
  localparam upc_t UA_RED_WAIT = 5'd4;
  localparam upc_t UA_RED_WB   = 5'd5;
  localparam upc_t UA_LOOP     = 5'd6;
  localparam upc_t UA_MUL_GO   = 5'd7;
  localparam upc_t UA_MUL_WAIT = 5'd8;
  localparam upc_t UA_MUL_WB   = 5'd9;
  localparam upc_t UA_SHIFT    = 5'd10;
  localparam upc_t UA_CHK_DONE = 5'd11;
  localparam upc_t UA_SQR_GO   = 5'd12;
  localparam upc_t UA_SQR_WAIT = 5'd13;
  localparam upc_t UA_SQR_WB   = 5'd14;
  localparam upc_t UA_EMIT     = 5'd15;
  localparam upc_t UA_ZERO     = 5'd16;

  localparam ctrl_word_t CW_NOP = '{
    cond: COND_NEXT, target: UA_IDLE, mul_go: 1'b0, msel: MSEL_ONE,
    wb: WB_NONE, shift_exp: 1'b0, emit: 1'b0, clr_acc: 1'b0
  };

  function automatic ctrl_word_t ucode_rom(upc_t addr);
    ctrl_word_t cw;
    cw = CW_NOP;
    unique case (addr)
      UA_IDLE: begin
        cw.cond   = COND_WAIT_START;
        cw.target = UA_IDLE;
      end
      UA_CHK_EXP: begin
        cw.cond   = COND_EXP_ZERO;
        cw.target = UA_EMIT;
      end
      UA_CHK_MOD: begin
        cw.cond   = COND_MOD_ZERO;
        cw.target = UA_ZERO;
      end
      UA_RED_GO: begin
        cw.mul_go = 1'b1;
        cw.msel   = MSEL_ONE;
      end
      UA_RED_WAIT: begin
        cw.cond   = COND_MUL_BUSY;
        cw.target = UA_RED_WAIT;
      end
      UA_RED_WB: begin
        cw.wb = WB_BASE;
      end
      UA_LOOP: begin
        cw.cond   = COND_BIT_CLR;
        cw.target = UA_SHIFT;
      end
      UA_MUL_GO: begin
        cw.mul_go = 1'b1;
        cw.msel   = MSEL_ACC;
      end
      UA_MUL_WAIT: begin
        cw.cond   = COND_MUL_BUSY;
        cw.target = UA_MUL_WAIT;
      end
      UA_MUL_WB: begin
        cw.wb = WB_ACC;
      end
      UA_SHIFT: begin
        cw.shift_exp = 1'b1;
      end
      UA_CHK_DONE: begin
        cw.cond   = COND_EXP_ZERO;
        cw.target = UA_EMIT;
      end
      UA_SQR_GO: begin
        cw.mul_go = 1'b1;
        cw.msel   = MSEL_BASE;
      end
      UA_SQR_WAIT: begin
        cw.cond   = COND_MUL_BUSY;
        cw.target = UA_SQR_WAIT;
      end
      UA_SQR_WB: begin
        cw.wb     = WB_BASE;
        cw.cond   = COND_ALWAYS;
        cw.target = UA_LOOP;
      end
      UA_EMIT: begin
        cw.emit   = 1'b1;
        cw.cond   = COND_ALWAYS;
        cw.target = UA_IDLE;
      end
      UA_ZERO: begin
        cw.clr_acc = 1'b1;
        cw.cond    = COND_ALWAYS;
        cw.target  = UA_EMIT;
      end
      default: begin
        cw.cond   = COND_ALWAYS;
        cw.target = UA_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

@@ src/modular_exponentiation.sv @@
`timescale 1ns / 1ps
// ============================================================================
// modular_exponentiation: base ** exponent mod modulus, square-and-multiply
// The base is first reduced mod the modulus, then each exponent bit up to the
// highest set bit takes a multiply when the bit is set and a square while bits
// remain; a zero exponent or a zero modulus goes straight to the result.
// One item at a time; busy stays high until done.
// Reset: synchronous active-high rst returns the sequencer to idle, no strobe.
// ============================================================================
module modular_exponentiation (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] base_value,
  input  logic [31:0] exponent_value,
  input  logic [31:0] modulus_value,
  output logic        done,
  output logic [31:0] power_result
);

  localparam int W = mexp_pkg::OPERAND_WIDTH;

  // Datapath registers
  mexp_pkg::operand_t base;
  mexp_pkg::operand_t expo;
  mexp_pkg::operand_t modv;
  mexp_pkg::operand_t acc;

  mexp_pkg::ctrl_word_t cw;
  mexp_pkg::status_t    status;
  mexp_pkg::operand_t   mul_a;
  mexp_pkg::operand_t   mul_r;
  logic                 mul_busy;
  logic                 accept;

  assign accept = start && !busy;

  assign status.start    = start;
  assign status.exp_zero = (expo == '0);
  assign status.exp_bit0 = expo[0];
  assign status.mod_zero = (modv == '0);
  assign status.mul_busy = mul_busy;

  // Multiplicand: one for the initial reduction of the base, else acc or base
  always_comb begin
    unique case (cw.msel)
      mexp_pkg::MSEL_ONE:  mul_a = mexp_pkg::operand_t'(1);
      mexp_pkg::MSEL_ACC:  mul_a = acc;
      mexp_pkg::MSEL_BASE: mul_a = base;
      default:             mul_a = base;
    endcase
  end

  mexp_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cw     (cw),
    .busy   (busy)
  );

  // The multiplier always takes base as its serial operand
  mexp_mulmod u_mulmod (
    .clk  (clk),
    .rst  (rst),
    .go   (cw.mul_go),
    .a    (mul_a),
    .b    (base),
    .m    (modv),
    .busy (mul_busy),
    .r    (mul_r)
  );

  // Load operands on an accepted beat, then follow the microcode
  always_ff @(posedge clk) begin
    if (accept) begin
      base <= base_value[W-1:0];
      expo <= exponent_value[W-1:0];
      modv <= modulus_value[W-1:0];
      acc  <= mexp_pkg::operand_t'(1);
    end else begin
      if (cw.wb == mexp_pkg::WB_BASE) begin
        base <= mul_r;
      end
      if (cw.wb == mexp_pkg::WB_ACC) begin
        acc <= mul_r;
      end
      if (cw.clr_acc) begin
        acc <= '0;
      end
      if (cw.shift_exp) begin
        expo <= expo >> 1;
      end
    end
  end

  // Result strobe: hold for exactly one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cw.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.emit) begin
      power_result <= 32'(acc);
    end
  end

endmodule

@@ src/mexp_mulmod.sv @@
`timescale 1ns / 1ps
// ============================================================================
// mexp_mulmod: bit-serial modular multiplier
// Computes a*b mod m by interleaved shift-and-subtract, one bit of b a cycle.
// ============================================================================
module mexp_mulmod (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  mexp_pkg::operand_t a,
  input  mexp_pkg::operand_t b,
  input  mexp_pkg::operand_t m,
  output logic               busy,
  output mexp_pkg::operand_t r
);

  localparam int W = mexp_pkg::OPERAND_WIDTH;

  typedef logic [mexp_pkg::CNT_W-1:0] cnt_t;

  logic [W-1:0] bsh;
  logic [W-1:0] a_hold;
  cnt_t         cnt;

  logic [W+1:0] x;
  logic [W+1:0] m1;
  logic [W+1:0] m2;
  logic [W+1:0] r_next;

  // x = 2r + a*bit stays below 3m, so one of x, x-m, x-2m is the residue
  always_comb begin
    x  = {1'b0, r, 1'b0} + (bsh[W-1] ? {2'b00, a_hold} : '0);
    m1 = {2'b00, m};
    m2 = {1'b0, m, 1'b0};
    priority if (x >= m2) begin
      r_next = x - m2;
    end else if (x >= m1) begin
      r_next = x - m1;
    end else begin
      r_next = x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (go) begin
      busy <= 1'b1;
    end else if (busy && (cnt == '0)) begin
      busy <= 1'b0;
    end
  end

  // Hold both operands from go on; the multiplicand select may move on
  always_ff @(posedge clk) begin
    if (go) begin
      r      <= '0;
      a_hold <= a;
      bsh    <= b;
      cnt    <= cnt_t'(W - 1);
    end else if (busy) begin
      r   <= r_next[W-1:0];
      bsh <= {bsh[W-2:0], 1'b0};
      cnt <= cnt - 1'b1;
    end
  end

endmodule

@@ src/mexp_ctrl.sv @@
`timescale 1ns / 1ps
// ============================================================================
// mexp_ctrl: microcode sequencer
// Steps through the program ROM and takes conditional jumps on datapath status.
// ============================================================================
module mexp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  mexp_pkg::status_t    status,
  output mexp_pkg::ctrl_word_t cw,
  output logic                 busy
);

  mexp_pkg::upc_t upc;
  mexp_pkg::upc_t upc_next;
  logic           taken;

  assign cw   = mexp_pkg::ucode_rom(upc);
  assign busy = (upc != mexp_pkg::UA_IDLE);

  always_comb begin
    unique case (cw.cond)
      mexp_pkg::COND_NEXT:       taken = 1'b0;
      mexp_pkg::COND_ALWAYS:     taken = 1'b1;
      mexp_pkg::COND_WAIT_START: taken = !status.start;
      mexp_pkg::COND_EXP_ZERO:   taken = status.exp_zero;
      mexp_pkg::COND_MOD_ZERO:   taken = status.mod_zero;
      mexp_pkg::COND_BIT_CLR:    taken = !status.exp_bit0;
      mexp_pkg::COND_MUL_BUSY:   taken = status.mul_busy;
      default:                   taken = 1'b1;
    endcase
    upc_next = taken ? cw.target : upc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= mexp_pkg::UA_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

endmodule
